// ----- rtl/eatc_pkg.sv -----
// Package for the address text checker: length limit, character codes,
// item and result structs, character class helpers. No dependencies.
package eatc_pkg;

  localparam int MAX_LEN = 255;
  localparam int COUNT_W = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_US   = 8'h5F;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic valid;
    logic is_valid;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

// ----- rtl/eatc_if.sv -----
// Handshake interfaces for the character input and verdict output channels.
// Depends on nothing.
interface eatc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface eatc_verdict_if;
  logic valid;
  logic ready;
  logic is_valid;
  modport source (output valid, output is_valid, input ready);
  modport sink (input valid, input is_valid, output ready);
endinterface

// ----- rtl/eatc_in_stage.sv -----
// Input register: captures one character transaction per cycle while it is empty or the scan takes its held character.
// Depends on eatc_pkg and eatc_char_if.
module eatc_in_stage (
  input  logic          clk,
  input  logic          rst,
  eatc_char_if.sink     chars,
  input  logic          take,
  output eatc_pkg::item_t item
);
  import eatc_pkg::*;

  assign chars.ready = !item.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (chars.ready) begin
      item.valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      item.ch <= chars.ch;
    end
  end
endmodule

// ----- rtl/eatc_scan.sv -----
// Per-character rule check: holds the scan state and forms the verdict
// on the terminator. Depends on eatc_pkg.
module eatc_scan (
  input  logic            clk,
  input  logic            rst,
  input  eatc_pkg::item_t item,
  input  logic            room,
  output logic            take,
  output eatc_pkg::res_t  res
);
  import eatc_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LOCAL,
    PH_DOMAIN
  } phase_t;

  phase_t               phase, phase_next;
  logic                 failed, failed_next;
  logic [COUNT_W-1:0]   char_count, char_count_next;
  logic [7:0]           prev_char, prev_char_next;
  logic                 label_open, label_open_next;
  logic                 seen_dot, seen_dot_next;
  logic [COUNT_W-1:0]   cnt_inc;
  logic                 cnt_full;
  logic                 term;

  assign term = (item.ch == CH_NUL);
  assign take = item.valid && (!term || room);

  assign res.valid    = take && term;
  assign res.is_valid = !failed && (phase == PH_DOMAIN) && label_open && seen_dot
                        && !is_digit(prev_char) && (char_count < COUNT_W'(MAX_LEN));

  assign cnt_inc  = (char_count < COUNT_W'(MAX_LEN)) ? char_count + 1'b1 : char_count;
  assign cnt_full = (cnt_inc >= COUNT_W'(MAX_LEN));

  always_comb begin
    phase_next      = phase;
    failed_next     = failed;
    char_count_next = char_count;
    prev_char_next  = item.ch;
    label_open_next = label_open;
    seen_dot_next   = seen_dot;
    if (term) begin
      phase_next      = PH_FIRST;
      failed_next     = 1'b0;
      char_count_next = '0;
      prev_char_next  = CH_NUL;
      label_open_next = 1'b0;
      seen_dot_next   = 1'b0;
    end else if (!failed) begin
      unique case (phase)
        PH_FIRST: begin
          failed_next     = !is_alnum(item.ch) || cnt_full;
          char_count_next = cnt_inc;
          phase_next      = PH_LOCAL;
        end
        PH_LOCAL: begin
          if (item.ch == CH_AT) begin
            failed_next = (prev_char == CH_DASH) || (prev_char == CH_US);
            phase_next  = PH_DOMAIN;
          end else begin
            failed_next = (!is_alnum(item.ch) && item.ch != CH_DASH && item.ch != CH_US)
                          || cnt_full;
            char_count_next = cnt_inc;
          end
        end
        PH_DOMAIN: begin
          if (is_alnum(item.ch)) begin
            label_open_next = 1'b1;
            failed_next     = cnt_full;
          end else if (label_open && (item.ch == CH_DASH || item.ch == CH_US)) begin
            failed_next = cnt_full;
          end else if (label_open && item.ch == CH_DOT) begin
            label_open_next = 1'b0;
            seen_dot_next   = 1'b1;
            failed_next     = cnt_full;
          end else begin
            failed_next = 1'b1;
          end
          char_count_next = cnt_inc;
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIRST;
      failed     <= 1'b0;
      char_count <= '0;
      prev_char  <= CH_NUL;
      label_open <= 1'b0;
      seen_dot   <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      failed     <= failed_next;
      char_count <= char_count_next;
      prev_char  <= prev_char_next;
      label_open <= label_open_next;
      seen_dot   <= seen_dot_next;
    end
  end
endmodule

// ----- rtl/eatc_out_stage.sv -----
// Result register: holds the verdict until the receiver takes it.
// Depends on eatc_pkg and eatc_verdict_if.
module eatc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  eatc_pkg::res_t res,
  output logic           room,
  eatc_verdict_if.source verdict
);
  import eatc_pkg::*;

  assign room = !verdict.valid || verdict.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (room) begin
      verdict.valid <= res.valid;
    end
    if (room && res.valid) begin
      verdict.is_valid <= res.is_valid;
    end
  end
endmodule

// ----- rtl/email_address_text_check.sv -----
// Address text checker top level: input register, rule scan, result register.
// Depends on eatc_pkg, eatc_if, eatc_in_stage, eatc_scan, eatc_out_stage.
//
// Channels: chars carries one byte per transaction; a zero byte ends the
// string. verdict carries one transaction per string, is_valid = 1 when the
// string has an acceptable address shape.
// Throughput: one byte per cycle, including terminators, while the verdict channel is not stalled.
// A terminator's verdict is registered in the result register once the scan takes it from the input register.
// Non-zero bytes produce no output transaction.
// Reset (rst, synchronous): clears both registers and the scan state, so
// the next byte starts a new string.
// Stall: while verdict is held with ready low, non-zero bytes keep flowing;
// a terminator waits in the input register, and chars.ready drops only
// then.
module email_address_text_check (
  input  logic           clk,
  input  logic           rst,
  eatc_char_if.sink      chars,
  eatc_verdict_if.source verdict
);
  import eatc_pkg::*;

  item_t item;
  res_t  res;
  logic  take;
  logic  room;

  eatc_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .take  (take),
    .item  (item)
  );

  eatc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .room (room),
    .take (take),
    .res  (res)
  );

  eatc_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .res     (res),
    .room    (room),
    .verdict (verdict)
  );
endmodule

// ----- rtl/eatc_checker.sv -----
// Port-level checks for the address text checker, bound to the top level.
// Depends on email_address_text_check.
module eatc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_valid
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_is_valid))
    else $error("verdict changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled verdict");

  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("reset did not empty the registers");

endmodule

bind email_address_text_check eatc_checker u_eatc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (chars.ready),
  .out_valid    (verdict.valid),
  .out_ready    (verdict.ready),
  .out_is_valid (verdict.is_valid)
);

// ----- test/email_address_text_check_tb.sv -----
// Testbench for email_address_text_check: drives address strings over the chars channel,
// predicts each verdict from its own scan of the rules and checks the verdict channel.
// Depends on eatc_pkg, eatc_if and the top level RTL.
`timescale 1ns / 1ps

module email_address_text_check_tb;
  import eatc_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int LATENCY_CYCLES = 4;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_TARGET   = 1650;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {SCAN_FIRST, SCAN_LOCAL, SCAN_DOMAIN} scan_phase_e;

  logic clk = 1'b0;
  logic rst;

  eatc_char_if    chars_if();
  eatc_verdict_if verdict_if();

  email_address_text_check i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .verdict(verdict_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // scan state of the predictor
  scan_phase_e        scan_phase;
  logic               scan_failed;
  logic [COUNT_W-1:0] scan_count;
  logic [7:0]         scan_prev;
  logic               scan_label_open;
  logic               scan_seen_dot;

  logic       verdict_q[$];
  logic [7:0] text_q[$];
  logic       want_verdict;
  int         mismatches = 0;
  int         items_sent = 0;
  int         quiet_cycles = 0;
  bit         idle_on = 1'b0;
  bit         hold_req = 1'b0;

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return digit_char(c) || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
           || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int pick;
    pick = $urandom_range(0, 61);
    if (pick < 10) return CH_ZERO + 8'(pick);
    if (pick < 36) return CH_UPPER_A + 8'(pick - 10);
    return CH_LOWER_A + 8'(pick - 36);
  endfunction

  function automatic logic [7:0] rand_joiner();
    return ($urandom_range(0, 1) == 0) ? CH_DASH : CH_US;
  endfunction

  task automatic reset_scan();
    scan_phase      = SCAN_FIRST;
    scan_failed     = 1'b0;
    scan_count      = '0;
    scan_prev       = CH_NUL;
    scan_label_open = 1'b0;
    scan_seen_dot   = 1'b0;
  endtask

  task automatic scan_char(input logic [7:0] c);
    logic counted;
    if (c == CH_NUL) begin
      verdict_q.push_back(!scan_failed && scan_phase == SCAN_DOMAIN && scan_label_open
                          && scan_seen_dot && !digit_char(scan_prev) && scan_count < MAX_LEN);
      reset_scan();
    end else begin
      if (!scan_failed) begin
        counted = 1'b1;
        case (scan_phase)
          SCAN_FIRST: begin
            scan_failed = !word_char(c);
            scan_phase  = SCAN_LOCAL;
          end
          SCAN_LOCAL: begin
            if (c == CH_AT) begin
              if (scan_prev == CH_DASH || scan_prev == CH_US) scan_failed = 1'b1;
              scan_phase = SCAN_DOMAIN;
              counted    = 1'b0;
            end else if (!word_char(c) && c != CH_DASH && c != CH_US) begin
              scan_failed = 1'b1;
            end
          end
          default: begin
            if (word_char(c)) begin
              scan_label_open = 1'b1;
            end else if (scan_label_open && (c == CH_DASH || c == CH_US)) begin
              // label stays open
            end else if (scan_label_open && c == CH_DOT) begin
              scan_label_open = 1'b0;
              scan_seen_dot   = 1'b1;
            end else begin
              scan_failed = 1'b1;
            end
          end
        endcase
        if (counted) begin
          if (scan_count < MAX_LEN) scan_count++;
          if (scan_count >= MAX_LEN) scan_failed = 1'b1;
        end
      end
      scan_prev = c;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_scan();
    end else begin
      if (verdict_if.valid && verdict_if.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %b with none pending", verdict_if.is_valid));
        end else begin
          want_verdict = verdict_q.pop_front();
          if (verdict_if.is_valid !== want_verdict)
            report_mismatch($sformatf("is_valid %b, predicted %b",
                                      verdict_if.is_valid, want_verdict));
        end
      end
      if (chars_if.valid && chars_if.ready) scan_char(chars_if.ch);
    end
  end

  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (verdict_if.valid && verdict_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // verdict receiver: random stalls, one long hold on request
  initial begin
    verdict_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        verdict_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        verdict_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      verdict_if.ready <= 1'b1;
    end
  end

  task automatic send_char(input logic [7:0] c);
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    items_sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
    send_char(CH_NUL);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    append_text(s);
    send_text();
  endtask

  task automatic drain_verdicts();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed addresses, some mutated, some pure noise
  task automatic build_address();
    int n_local;
    int n_labels;
    int n_chars;
    int pos;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    n_local = $urandom_range(1, 8);
    for (int i = 0; i < n_local; i++)
      text_q.push_back((i == 0 || i == n_local - 1 || $urandom_range(0, 3) != 0)
                       ? rand_word_char() : rand_joiner());
    text_q.push_back(CH_AT);
    n_labels = $urandom_range(2, 4);
    for (int l = 0; l < n_labels; l++) begin
      if (l > 0) text_q.push_back(CH_DOT);
      n_chars = $urandom_range(1, 6);
      for (int i = 0; i < n_chars; i++)
        text_q.push_back((i == 0 || $urandom_range(0, 3) != 0) ? rand_word_char() : rand_joiner());
    end
    if ($urandom_range(0, 3) != 0) text_q[text_q.size() - 1] = CH_LOWER_A + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 2) == 0) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 5))
        0: text_q[pos] = 8'($urandom_range(1, 255));
        1: text_q[pos] = CH_AT;
        2: text_q[pos] = CH_DOT;
        3: text_q[pos] = rand_joiner();
        4: text_q.insert(pos, CH_DOT);
        default: while (text_q.size() > pos + 1) void'(text_q.pop_back());
      endcase
    end
  endtask

  task automatic test_directed_cases();
    idle_on = 1'b1;
    send_string("");
    text_q = '{8'hFF, 8'h01};
    send_text();
    send_string("z");
    send_string("Z@@");
    send_string("b-@x.y");
    send_string("a@b_.c");
    send_string("q@r.5");
    drain_verdicts();
  endtask

  // just under, at and past the length limit
  task automatic test_length_limit();
    int lengths[3];
    idle_on = 1'b1;
    lengths = '{MAX_LEN - 1, MAX_LEN, MAX_LEN + 3};
    foreach (lengths[k]) begin
      text_q.delete();
      repeat (lengths[k] - 4) text_q.push_back(CH_LOWER_A);
      append_text("@b.cd");
      send_text();
    end
    drain_verdicts();
  endtask

  task automatic test_random_addresses();
    while (items_sent < ITEMS_TARGET - 250) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_address();
      send_text();
    end
    drain_verdicts();
  endtask

  // receiver holds off while strings keep coming, so the input stalls
  task automatic test_verdict_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (12) begin
      build_address();
      send_text();
    end
    drain_verdicts();
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    while (items_sent < ITEMS_TARGET) begin
      build_address();
      send_text();
    end
  endtask

  initial begin
    rst            <= 1'b1;
    chars_if.valid <= 1'b0;
    chars_if.ch    <= CH_NUL;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_length_limit();
    test_random_addresses();
    test_verdict_backpressure();
    test_full_rate();
    drain_verdicts();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
